[rtl/core/psc_pkg.sv]
// Shared types and constants for the pressure sensor compensation block.
// No dependencies.
package psc_pkg;

    localparam int MUL_W = 32;

    typedef logic signed [MUL_W-1:0]   t_mop;
    typedef logic signed [2*MUL_W-1:0] t_prod;

    // calibration register indexes
    typedef enum logic [2:0] {
        REG_C1 = 3'd0,
        REG_C2 = 3'd1,
        REG_C3 = 3'd2,
        REG_C4 = 3'd3,
        REG_C5 = 3'd4,
        REG_C6 = 3'd5
    } t_reg_idx;

    localparam int REF_TEMP_CENTI  = 2000;
    localparam int VLOW_TEMP_CENTI = 1500;
    // offset of the very-low branch measured from the reference temperature
    localparam int VLOW_FROM_REF   = REF_TEMP_CENTI + VLOW_TEMP_CENTI;

    // reciprocals: q = (n * RECIP10) >> 34 exact for n < 2^30,
    //              q = (n * RECIP49) >> 36 exact for n < 2^30
    localparam logic [30:0] RECIP10 = 31'd1717986919;
    localparam logic [30:0] RECIP49 = 31'd1402438302;

endpackage

[rtl/core/pressure_sensor_compensation.sv]
// Pressure sensor second-order temperature compensation, top level.
// Depends on psc_pkg and psc_mul.
// Each accepted item passes through all sequencer steps after idle before its
//   result is valid. Input is ready only in idle, so a new item is taken only
//   once the sequencer is back in idle (later while an older result is stalled).
// All products go through the one 32x32 multiplier in psc_mul, at most one per step.
// Reset (synchronous, active low) clears calibration words, baseline,
//   sequencer and output valid.
module pressure_sensor_compensation (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // calibration write port
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_addr,
    input  logic [15:0]        i_cfg_wdata,
    // input items
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [23:0]        i_raw_pressure,
    input  logic [23:0]        i_raw_temperature,
    // result items
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [18:0] o_first_order_temperature,
    output logic signed [19:0] o_compensated_temperature,
    output logic signed [23:0] o_compensated_pressure,
    output logic signed [23:0] o_baseline_out,
    output logic [23:0]        o_depth_value
);
    import psc_pkg::*;

    // Sequencer: at most one multiply issued per step, its product consumed in the
    // following step, where the next multiply, if any, is issued.
    typedef enum logic [4:0] {
        S_IDLE, S_DT, S_MT, S_TEMP, S_T2, S_AA, S_BB, S_OFF, S_SENS,
        S_PL, S_PH, S_PS, S_PO, S_ABS, S_DIV, S_Q, S_BASE, S_DEP, S_FIN
    } t_state;

    t_state r_state;

    logic [15:0]        r_cal [6];
    logic [23:0]        r_d1, r_d2;
    logic signed [24:0] r_dt;     // D2 - C5*256
    logic signed [17:0] r_a;      // TEMP - 2000
    logic [18:0]        r_t2;
    logic [37:0]        r_off2, r_sens2;
    logic signed [41:0] r_off, r_sens;
    logic signed [63:0] r_acc;    // D1 * SENS
    logic signed [30:0] r_y;
    logic [29:0]        r_mag;
    logic               r_neg;
    logic signed [23:0] r_p;      // saturated pressure
    logic signed [23:0] r_base;
    logic [23:0]        r_diff;

    logic               r_out_valid;
    logic signed [18:0] r_o_temp1;
    logic signed [19:0] r_o_temp2;
    logic signed [23:0] r_o_p;
    logic signed [23:0] r_o_base;
    logic [23:0]        r_o_depth;

    t_mop  w_ma, w_mb;
    t_prod w_prod;

    psc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    // combinational helpers
    logic signed [18:0] w_b;      // TEMP + 1500
    logic signed [18:0] w_temp;
    logic [51:0]        w_sq3;
    logic [37:0]        w_aa3, w_aa5, w_bb7, w_bb4;
    logic signed [43:0] w_ydiff;
    logic signed [26:0] w_pq;
    logic signed [23:0] w_pq_sat;
    logic signed [23:0] w_nb;
    logic signed [24:0] w_pdiff;
    logic [24:0]        w_dep;
    logic signed [20:0] w_tc;
    logic               w_done;

    assign w_b    = 19'(r_a) + 19'(VLOW_FROM_REF);
    assign w_temp = 19'(r_a) + 19'(REF_TEMP_CENTI);
    assign w_sq3  = {2'd0, w_prod[49:0]} + {1'b0, w_prod[49:0], 1'b0};
    assign w_aa3  = {3'd0, w_prod[34:0]} + {2'd0, w_prod[34:0], 1'b0};
    assign w_aa5  = {3'd0, w_prod[34:0]} + {1'd0, w_prod[34:0], 2'b0};
    assign w_bb7  = {w_prod[34:0], 3'b0} - {3'd0, w_prod[34:0]};
    assign w_bb4  = {1'b0, w_prod[34:0], 2'b0};
    assign w_ydiff = 44'(r_acc >>> 21) - 44'(r_off);
    assign w_pq   = r_neg ? -$signed({1'b0, w_prod[59:34]}) : $signed({1'b0, w_prod[59:34]});
    assign w_pq_sat = (w_pq > 27'sd8388607)  ? 24'sh7FFFFF :
                      (w_pq < -27'sd8388608) ? 24'sh800000 : w_pq[23:0];
    assign w_nb    = (r_base == '0) ? r_p : r_base;
    assign w_pdiff = 25'(r_p) - 25'(w_nb);
    assign w_dep   = {1'b0, r_diff} + {5'd0, w_prod[55:36]};
    assign w_tc    = 21'(w_temp) - $signed({2'b0, r_t2});
    assign w_done  = !r_out_valid || i_out_ready;

    assign o_in_ready = (r_state == S_IDLE);

    // multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_MT: begin
                w_ma = MUL_W'(r_dt);
                w_mb = $signed({16'd0, r_cal[REG_C6]});
            end
            S_TEMP: begin
                w_ma = MUL_W'(r_dt);
                w_mb = MUL_W'(r_dt);
            end
            S_T2: begin
                w_ma = MUL_W'(r_a);
                w_mb = MUL_W'(r_a);
            end
            S_AA: begin
                w_ma = MUL_W'(w_b);
                w_mb = MUL_W'(w_b);
            end
            S_BB: begin
                w_ma = MUL_W'(r_dt);
                w_mb = $signed({16'd0, r_cal[REG_C4]});
            end
            S_OFF: begin
                w_ma = MUL_W'(r_dt);
                w_mb = $signed({16'd0, r_cal[REG_C3]});
            end
            S_PL: begin
                w_ma = $signed({8'd0, r_d1});
                w_mb = $signed({12'd0, r_sens[19:0]});
            end
            S_PH: begin
                w_ma = $signed({8'd0, r_d1});
                w_mb = MUL_W'($signed(r_sens[41:20]));
            end
            S_DIV: begin
                w_ma = $signed({2'd0, r_mag});
                w_mb = $signed({1'b0, RECIP10});
            end
            // kept up in the final step so the quotient survives an output stall
            S_DEP, S_FIN: begin
                w_ma = $signed({8'd0, r_diff});
                w_mb = $signed({1'b0, RECIP49});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // calibration words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) r_cal[i] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_C1:  r_cal[REG_C1] <= i_cfg_wdata;
                REG_C2:  r_cal[REG_C2] <= i_cfg_wdata;
                REG_C3:  r_cal[REG_C3] <= i_cfg_wdata;
                REG_C4:  r_cal[REG_C4] <= i_cfg_wdata;
                REG_C5:  r_cal[REG_C5] <= i_cfg_wdata;
                REG_C6:  r_cal[REG_C6] <= i_cfg_wdata;
                default: ;  // unknown index ignored
            endcase
        end
    end

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // the final step sets valid itself when it completes
            if (r_out_valid && i_out_ready && r_state != S_FIN) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_d1    <= i_raw_pressure;
                        r_d2    <= i_raw_temperature;
                        r_state <= S_DT;
                    end
                end
                S_DT: begin
                    r_dt    <= $signed({1'b0, r_d2}) - $signed({1'b0, r_cal[REG_C5], 8'd0});
                    r_state <= S_MT;
                end
                S_MT:   r_state <= S_TEMP;
                S_TEMP: begin
                    r_a     <= $signed(w_prod[40:23]);
                    r_state <= S_T2;
                end
                S_T2: begin
                    // low branch: 3*dT^2 >> 33, high: 2*dT^2 >> 37
                    r_t2    <= r_a[17] ? w_sq3[51:33] : {5'd0, w_prod[49:36]};
                    r_state <= S_AA;
                end
                S_AA: begin
                    if (r_a[17]) begin
                        r_off2  <= {1'b0, w_aa3[37:1]};
                        r_sens2 <= {3'd0, w_aa5[37:3]};
                    end else begin
                        r_off2  <= {7'd0, w_prod[34:4]};
                        r_sens2 <= '0;
                    end
                    r_state <= S_BB;
                end
                S_BB: begin
                    // very-low branch: TEMP below -15.00 C
                    if (r_a < -18'(VLOW_FROM_REF)) begin
                        r_off2  <= r_off2 + w_bb7;
                        r_sens2 <= r_sens2 + w_bb4;
                    end
                    r_state <= S_OFF;
                end
                S_OFF: begin
                    r_off <= $signed({10'd0, r_cal[REG_C2], 16'd0})
                           + 42'($signed(w_prod[40:7]))
                           - $signed({4'd0, r_off2});
                    r_state <= S_SENS;
                end
                S_SENS: begin
                    r_sens <= $signed({11'd0, r_cal[REG_C1], 15'd0})
                            + 42'($signed(w_prod[40:8]))
                            - $signed({4'd0, r_sens2});
                    r_state <= S_PL;
                end
                S_PL:   r_state <= S_PH;
                S_PH: begin
                    r_acc   <= w_prod;
                    r_state <= S_PS;
                end
                S_PS: begin
                    r_acc   <= r_acc + (w_prod <<< 20);
                    r_state <= S_PO;
                end
                S_PO: begin
                    r_y     <= w_ydiff[43:13];
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    r_neg   <= r_y[30];
                    r_mag   <= r_y[30] ? 30'(-r_y) : 30'(r_y);
                    r_state <= S_DIV;
                end
                S_DIV:  r_state <= S_Q;
                S_Q: begin
                    r_p     <= w_pq_sat;
                    r_state <= S_BASE;
                end
                S_BASE: begin
                    r_base  <= w_nb;
                    r_diff  <= w_pdiff[24] ? 24'd0 : w_pdiff[23:0];
                    r_state <= S_DEP;
                end
                S_DEP:  r_state <= S_FIN;
                S_FIN: begin
                    // hold here while the previous result is still unclaimed
                    if (w_done) begin
                        r_o_temp1   <= w_temp;
                        r_o_temp2   <= (w_tc > 21'sd524287)  ? 20'sh7FFFF :
                                       (w_tc < -21'sd524288) ? 20'sh80000 : w_tc[19:0];
                        r_o_p       <= r_p;
                        r_o_base    <= r_base;
                        r_o_depth   <= w_dep[24] ? 24'hFFFFFF : w_dep[23:0];
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid               = r_out_valid;
    assign o_first_order_temperature = r_o_temp1;
    assign o_compensated_temperature = r_o_temp2;
    assign o_compensated_pressure    = r_o_p;
    assign o_baseline_out            = r_o_base;
    assign o_depth_value             = r_o_depth;

    // once latched, the baseline never changes
    a_base_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_base != '0) |=> $stable(r_base))
        else $error("baseline changed after latch");

    // nonzero depth only when pressure is above the baseline
    a_depth_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_depth_value != '0) |->
        (o_compensated_pressure > o_baseline_out))
        else $error("depth without pressure above baseline");

    // a new item is only taken once the sequencer has returned to idle
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DT))
        else $error("accepted item did not start sequence");

    // a result is never overwritten while waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_o_p)))
        else $error("pending result overwritten");

endmodule

[rtl/core/psc_mul.sv]
// Shared signed multiplier with registered product.
// Depends on psc_pkg.
module psc_mul (
    input  logic          i_clk,
    input  psc_pkg::t_mop i_a,
    input  psc_pkg::t_mop i_b,
    output psc_pkg::t_prod o_p
);
    import psc_pkg::*;

    t_prod r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

[sim/psc_checker.sv]
// Result checker for pressure_sensor_compensation: watches the config port and both channels,
// predicts each result and compares it with the next one that comes out. Depends on psc_pkg.
module psc_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_addr,
    input  logic [15:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [23:0]        i_raw_pressure,
    input  logic [23:0]        i_raw_temperature,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [18:0] i_first_order_temperature,
    input  logic signed [19:0] i_compensated_temperature,
    input  logic signed [23:0] i_compensated_pressure,
    input  logic signed [23:0] i_baseline_out,
    input  logic [23:0]        i_depth_value,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_results
);
    timeunit 1ns;
    timeprecision 1ps;
    import psc_pkg::*;

    typedef struct packed {
        logic signed [18:0] temp1;
        logic signed [19:0] temp2;
        logic signed [23:0] press;
        logic signed [23:0] base;
        logic [23:0]        depth;
    } t_reading;

    t_reading           expected_q[$];
    logic [15:0]        calib[6];
    logic signed [63:0] surface_mbar;

    function automatic longint floor_shr(longint x, int n);
        return x >>> n;
    endfunction

    function automatic longint clamp(longint v, int bits);
        longint hi;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // full second-order compensation of one raw pair; updates the surface baseline
    function automatic t_reading compensate(logic [23:0] d1_raw, logic [23:0] d2_raw);
        longint d1, dt, temp, t2, off2, sens2, off, sens, p, a, b, diff, dep;
        t_reading r;
        d1 = longint'(d1_raw);
        dt = longint'(d2_raw) - longint'(calib[REG_C5]) * 256;
        temp = REF_TEMP_CENTI + floor_shr(dt * longint'(calib[REG_C6]), 23);
        a = temp - REF_TEMP_CENTI;
        if (temp < REF_TEMP_CENTI) begin
            t2 = (3 * (dt * dt)) >>> 33;
            off2 = (3 * a * a) / 2;
            sens2 = (5 * a * a) / 8;
            if (temp < -VLOW_TEMP_CENTI) begin
                b = temp + VLOW_TEMP_CENTI;
                off2 += 7 * b * b;
                sens2 += 4 * b * b;
            end
        end else begin
            t2 = (2 * (dt * dt)) >>> 37;
            off2 = (a * a) >>> 4;
            sens2 = 0;
        end
        off = longint'(calib[REG_C2]) * 65536
            + floor_shr(longint'(calib[REG_C4]) * dt, 7) - off2;
        sens = longint'(calib[REG_C1]) * 32768
            + floor_shr(longint'(calib[REG_C3]) * dt, 8) - sens2;
        p = clamp(floor_shr(floor_shr(d1 * sens, 21) - off, 13) / 10, 24);
        if (surface_mbar == 0) surface_mbar = p;
        diff = p - surface_mbar;
        if (diff < 0) diff = 0;
        dep = (diff * 50) / 49;
        if (dep > 64'sd16777215) dep = 64'sd16777215;
        r.temp1 = 19'(clamp(temp, 19));
        r.temp2 = 20'(clamp(temp - t2, 20));
        r.press = 24'(p);
        r.base = 24'(surface_mbar);
        r.depth = 24'(dep);
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            foreach (calib[i]) calib[i] = '0;
            surface_mbar = 0;
            expected_q.delete();
        end else begin
            if (i_cfg_we && i_cfg_addr <= REG_C6) calib[i_cfg_addr] = i_cfg_wdata;
            if (i_in_valid && i_in_ready)
                expected_q.push_back(compensate(i_raw_pressure, i_raw_temperature));
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (expected_q.size() == 0) begin
                    report("unexpected result", 0, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (i_first_order_temperature !== want.temp1)
                        report("first_order_temperature", i_first_order_temperature, want.temp1);
                    if (i_compensated_temperature !== want.temp2)
                        report("compensated_temperature", i_compensated_temperature, want.temp2);
                    if (i_compensated_pressure !== want.press)
                        report("compensated_pressure", i_compensated_pressure, want.press);
                    if (i_baseline_out !== want.base)
                        report("baseline_out", i_baseline_out, want.base);
                    if (i_depth_value !== want.depth)
                        report("depth_value", i_depth_value, want.depth);
                end
            end
        end
        o_pending = expected_q.size();
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_results = 0;
    end
endmodule

[sim/testbench.sv]
// Top of the pressure_sensor_compensation testbench: clock, reset, calibration phases,
// stimulus and verdict. Depends on psc_pkg, psc_checker and the block itself.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import psc_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 40;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_addr = '0;
    logic [15:0] i_cfg_wdata = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [23:0] i_raw_pressure = '0;
    logic [23:0] i_raw_temperature = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [18:0] o_first_order_temperature;
    logic signed [19:0] o_compensated_temperature;
    logic signed [23:0] o_compensated_pressure;
    logic signed [23:0] o_baseline_out;
    logic [23:0] o_depth_value;

    int errors, pending, results;
    int cycle_count = 0;
    int sent = 0;
    int phases = 0;
    bit hold_off = 1'b0;     // long receiver stall, forces input backpressure
    bit drain_full = 1'b0;   // receiver always ready while draining

    always #10 i_clk = ~i_clk;

    pressure_sensor_compensation i_dut (.*);

    psc_checker i_chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_addr, .i_cfg_wdata,
        .i_in_valid, .i_in_ready(o_in_ready), .i_raw_pressure, .i_raw_temperature,
        .i_out_valid(o_out_valid), .i_out_ready,
        .i_first_order_temperature(o_first_order_temperature),
        .i_compensated_temperature(o_compensated_temperature),
        .i_compensated_pressure(o_compensated_pressure),
        .i_baseline_out(o_baseline_out), .i_depth_value(o_depth_value),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("pressure_sensor_compensation: mismatch");
            $finish;
        end
    end

    // receiver: stalls on its own pattern, sometimes in long runs
    initial begin
        int mode;
        mode = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off) i_out_ready <= 1'b0;
            else if (drain_full) i_out_ready <= 1'b1;
            else begin
                if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 3) != 0);
                    default: i_out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // send one item; valid stays up across back-to-back items
    task automatic send_item(logic [23:0] d1, logic [23:0] d2, bit last_in_burst);
        i_in_valid <= 1'b1;
        i_raw_pressure <= d1;
        i_raw_temperature <= d2;
        do @(posedge i_clk); while (!o_in_ready);
        sent++;
        if (last_in_burst) i_in_valid <= 1'b0;
    endtask

    // bursts with random gaps between them
    task automatic send_random(int count, bit typical);
        int burst;
        logic [23:0] d1, d2;
        burst = 0;
        for (int k = 0; k < count; k++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40))
                    @(posedge i_clk);
            end
            if (typical && $urandom_range(0, 7) != 0) begin
                // sensor-like readings near the reference point
                d1 = 24'(4000000 + $urandom_range(0, 8000000));
                d2 = 24'(6000000 + $urandom_range(0, 4000000));
            end else begin
                d1 = 24'($urandom);
                d2 = 24'($urandom);
            end
            burst--;
            send_item(d1, d2, burst == 0 || k == count - 1);
        end
    endtask

    task automatic wait_idle();
        drain_full = 1'b1;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        drain_full = 1'b0;
    endtask

    task automatic load_calib(logic [15:0] c1, c2, c3, c4, c5, c6);
        write_reg(REG_C1, c1);
        write_reg(REG_C2, c2);
        write_reg(REG_C3, c3);
        write_reg(REG_C4, c4);
        write_reg(REG_C5, c5);
        write_reg(REG_C6, c6);
        phases++;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unset calibration: all words zero
        send_item(24'd0, 24'd0, 1'b1);
        send_item(24'hFFFFFF, 24'hFFFFFF, 1'b1);
        wait_idle();

        // typical calibration; first nonzero pressure latches baseline
        load_calib(16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165);
        send_item(24'd6465444, 24'd8077636, 1'b1);
        send_item(24'd6500000, 24'd8077636, 1'b0);   // above baseline: depth > 0
        send_item(24'd6400000, 24'd8077636, 1'b1);   // below baseline: depth 0
        send_item(24'd6465444, 24'd2000000, 1'b1);   // also very low temperature
        send_item(24'd6465444, 24'd0, 1'b1);         // very low temperature
        send_item(24'd6465444, 24'hFFFFFF, 1'b1);    // high temperature
        send_item(24'd0, 24'd8077636, 1'b0);
        send_item(24'hFFFFFF, 24'd0, 1'b0);
        send_item(24'hFFFFFF, 24'hFFFFFF, 1'b1);
        send_item(24'h555555, 24'hAAAAAA, 1'b0);
        send_item(24'hAAAAAA, 24'h555555, 1'b1);
        wait_idle();
        // write to an index past the last register is dropped
        i_cfg_we <= 1'b1; i_cfg_addr <= 3'd6; i_cfg_wdata <= 16'hFFFF;
        @(posedge i_clk);
        i_cfg_addr <= 3'd7;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        send_random(190, 1'b1);
        wait_idle();

        // extremes: all ones, pushes intermediates and saturation
        load_calib(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(24'd0, 24'd0, 1'b1);
        send_item(24'hFFFFFF, 24'd0, 1'b1);
        send_item(24'hFFFFFF, 24'hFFFFFF, 1'b1);
        send_random(100, 1'b0);
        wait_idle();

        // zero offset words, strong sensitivity: large depths
        load_calib(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
        send_random(100, 1'b0);
        wait_idle();

        // hold the receiver off while items keep coming so the block stalls its input
        load_calib(16'd40000, 16'd36000, 16'd23000, 16'd23000, 16'd33000, 16'd28000);
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge i_clk);
                hold_off = 1'b0;
            end
            send_random(40, 1'b1);
        join
        wait_idle();

        // several random calibrations
        for (int ph = 0; ph < 6; ph++) begin
            load_calib(16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom), 16'($urandom));
            send_random(100, 1'b1);
            wait_idle();
        end

        $display("covered %0d items, %0d results over %0d calibration sets",
                 sent, results, phases);
        $display("incl. zero and all-ones calibration, saturation and a long output stall");
        if (errors == 0)
            $display("pressure_sensor_compensation: match");
        else
            $display("pressure_sensor_compensation: mismatch");
        $finish;
    end
endmodule
